// ===== rtl/core/flux_adv_pkg.sv =====
// ---------------------------------------------------------------------------
// flux_adv_pkg
// Shared widths, constants and fixed-point helpers for the flux-form
// advection cell.
// ---------------------------------------------------------------------------
package flux_adv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int RATIO_W   = 20;
   localparam int WIDE_W    = 2 * WORD_W + 2;
   localparam int STAGES    = 6;

   localparam logic signed [WIDE_W-1:0] WORD_MAX  = (WIDE_W'(1) <<< (WORD_W - 1)) - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] WORD_MIN  = -(WIDE_W'(1) <<< (WORD_W - 1));
   localparam logic signed [WIDE_W-1:0] HALF_LSB  = WIDE_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [WIDE_W-1:0] ONE_WIDE  = WIDE_W'(1) <<< FRAC_BITS;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [RATIO_W-1:0]       ratio_type;

   function automatic logic signed [WIDE_W-1:0] ext_word(input logic signed [WORD_W-1:0] x);
      return {{(WIDE_W-WORD_W){x[WORD_W-1]}}, x};
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x);
      logic signed [WORD_W-1:0] y;
      if (x > WORD_MAX) begin
         y = WORD_MAX[WORD_W-1:0];
      end else if (x < WORD_MIN) begin
         y = WORD_MIN[WORD_W-1:0];
      end else begin
         y = x[WORD_W-1:0];
      end
      return y;
   endfunction

   // round half up to the fixed-point grid, then clamp
   function automatic logic signed [WORD_W-1:0] round_prod(input logic signed [WIDE_W-1:0] p);
      logic signed [WIDE_W-1:0] t;
      t = (p + HALF_LSB) >>> FRAC_BITS;
      return sat_word(t);
   endfunction

endpackage

// ===== rtl/core/flux_adv_face.sv =====
// ---------------------------------------------------------------------------
// flux_adv_face
// Five-stage pipeline for the upwind flux through one cell face.
// ---------------------------------------------------------------------------
module flux_adv_face
   import flux_adv_pkg::*;
(
   input  logic      clock,
   input  ratio_type ratio,
   input  word_type  vel,
   input  word_type  q_a,
   input  word_type  q_b,
   input  word_type  q_c,
   input  word_type  q_d,
   output word_type  flux
);

   localparam logic signed [WORD_W:0] ONE_EXT  = (WORD_W+1)'(1) <<< FRAC_BITS;
   localparam logic signed [WORD_W:0] QTR_HALF = (WORD_W+1)'(2);
   localparam int RPROD_W = WORD_W + RATIO_W;

   // stage 1: magnitude, stencil selection
   logic [WORD_W-1:0] mag_ff, mag_in;
   word_type base1_ff, base1_in;
   word_type slope1_ff, slope1_in;
   // stage 2: courant magnitude
   word_type r2_ff, r2_in;
   word_type base2_ff;
   word_type slope2_ff;
   // stage 3: slope correction
   word_type r3_ff;
   word_type base3_ff;
   word_type corr3_ff, corr3_in;
   // stage 4: upwind value
   word_type r4_ff;
   word_type sum4_ff, sum4_in;
   // stage 5: flux
   word_type flux5_ff, flux5_in;

   logic [RPROD_W-1:0]          rprod;
   logic signed [WORD_W:0]      omr;
   logic signed [WORD_W:0]      quarter;
   logic signed [2*WORD_W-1:0]  cprod;
   logic signed [2*WORD_W-1:0]  fprod;

   always_comb begin
      mag_in = vel[WORD_W-1] ? (~vel + WORD_W'(1)) : vel;
      if (!vel[WORD_W-1]) begin
         base1_in  = q_b;
         slope1_in = sat_word(ext_word(q_c) - ext_word(q_a));
      end else begin
         base1_in  = sat_word(-ext_word(q_c));
         slope1_in = sat_word(ext_word(q_d) - ext_word(q_b));
      end
   end

   assign rprod = mag_ff * ratio;
   assign r2_in = round_prod({{(WIDE_W-RPROD_W){1'b0}}, rprod});

   // 0.25*(1-r), rounded half up
   assign omr      = ONE_EXT - {r2_ff[WORD_W-1], r2_ff};
   assign quarter  = (omr + QTR_HALF) >>> 2;
   assign cprod    = $signed(quarter[WORD_W-1:0]) * slope2_ff;
   assign corr3_in = round_prod({{(WIDE_W-2*WORD_W){cprod[2*WORD_W-1]}}, cprod});

   assign sum4_in = sat_word(ext_word(base3_ff) + ext_word(corr3_ff));

   assign fprod    = r4_ff * sum4_ff;
   assign flux5_in = round_prod({{(WIDE_W-2*WORD_W){fprod[2*WORD_W-1]}}, fprod});

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      base1_ff  <= base1_in;
      slope1_ff <= slope1_in;
      r2_ff     <= r2_in;
      base2_ff  <= base1_ff;
      slope2_ff <= slope1_ff;
      r3_ff     <= r2_ff;
      base3_ff  <= base2_ff;
      corr3_ff  <= corr3_in;
      r4_ff     <= r3_ff;
      sum4_ff   <= sum4_in;
      flux5_ff  <= flux5_in;
   end

   assign flux = flux5_ff;

endmodule

// ===== rtl/core/flux_adv_growth.sv =====
// ---------------------------------------------------------------------------
// flux_adv_growth
// Five-stage pipeline for the divergence growth term q*(1+dv*ratio).
// ---------------------------------------------------------------------------
module flux_adv_growth
   import flux_adv_pkg::*;
(
   input  logic      clock,
   input  ratio_type ratio,
   input  word_type  vel_left,
   input  word_type  vel_right,
   input  word_type  q_center,
   output word_type  scaled
);

   localparam int GPROD_W = WORD_W + RATIO_W + 1;

   word_type dv1_ff, dv1_in;
   word_type q1_ff;
   word_type g2_ff, g2_in;
   word_type q2_ff;
   word_type grow3_ff, grow3_in;
   word_type q3_ff;
   word_type scaled4_ff, scaled4_in;
   word_type scaled5_ff;

   logic signed [GPROD_W-1:0]   gprod;
   logic signed [2*WORD_W-1:0]  sprod;

   assign dv1_in = sat_word(ext_word(vel_right) - ext_word(vel_left));

   assign gprod = dv1_ff * $signed({1'b0, ratio});
   assign g2_in = round_prod({{(WIDE_W-GPROD_W){gprod[GPROD_W-1]}}, gprod});

   assign grow3_in = sat_word(ONE_WIDE + ext_word(g2_ff));

   assign sprod      = q3_ff * grow3_ff;
   assign scaled4_in = round_prod({{(WIDE_W-2*WORD_W){sprod[2*WORD_W-1]}}, sprod});

   always_ff @(posedge clock) begin
      dv1_ff     <= dv1_in;
      q1_ff      <= q_center;
      g2_ff      <= g2_in;
      q2_ff      <= q1_ff;
      grow3_ff   <= grow3_in;
      q3_ff      <= q2_ff;
      scaled4_ff <= scaled4_in;
      // align with the face flux stage
      scaled5_ff <= scaled4_ff;
   end

   assign scaled = scaled5_ff;

endmodule

// ===== rtl/core/flux_advection_cell_top.sv =====
// ---------------------------------------------------------------------------
// flux_form_advection_cell_top
// Piecewise-linear upwind flux-form advection of one grid cell, Q15.16.
// ---------------------------------------------------------------------------
// Usage:
//   A word is the cell's five-point scalar window plus its face velocities,
//   taken at a clock edge with start high and busy low. busy stays low: the
//   pipeline takes one word every cycle with no gaps.
//   Each result appears on rsp_new_q for one cycle with rsp_valid high,
//   once its word has passed the register stages below, and is taken then.
//   Six register stages: magnitude and stencil pick, courant product, slope
//   correction, upwind sum, flux product, face difference and subtract.
//   Throughput is one word per cycle.
//   csr_data sets courant_ratio (unsigned Q4.16) on an edge with csr_valid
//   high; csr_ready is always high. Write it only while no word is in
//   flight.
//   Reset (synchronous, active high) clears the stage valid bits and sets
//   courant_ratio to zero. The receiver cannot stall, so results are never
//   held back.
// ---------------------------------------------------------------------------
module flux_form_advection_cell_top
   import flux_adv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  word_type  req_q_minus2,
   input  word_type  req_q_minus1,
   input  word_type  req_q_center,
   input  word_type  req_q_plus1,
   input  word_type  req_q_plus2,
   input  word_type  req_vel_left,
   input  word_type  req_vel_right,
   output logic      rsp_valid,
   output word_type  rsp_new_q,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  ratio_type csr_data
);

   ratio_type           ratio_ff, ratio_in;
   logic [STAGES-1:0]   vld_ff, vld_in;
   word_type            res_ff, res_in;
   word_type            flux_left;
   word_type            flux_right;
   word_type            scaled;
   word_type            flux_diff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign ratio_in = (csr_valid && csr_ready) ? csr_data : ratio_ff;
   assign vld_in   = {vld_ff[STAGES-2:0], start && !busy};

   flux_adv_face u_face_left (
      .clock (clock),
      .ratio (ratio_ff),
      .vel   (req_vel_left),
      .q_a   (req_q_minus2),
      .q_b   (req_q_minus1),
      .q_c   (req_q_center),
      .q_d   (req_q_plus1),
      .flux  (flux_left)
   );

   flux_adv_face u_face_right (
      .clock (clock),
      .ratio (ratio_ff),
      .vel   (req_vel_right),
      .q_a   (req_q_minus1),
      .q_b   (req_q_center),
      .q_c   (req_q_plus1),
      .q_d   (req_q_plus2),
      .flux  (flux_right)
   );

   flux_adv_growth u_growth (
      .clock     (clock),
      .ratio     (ratio_ff),
      .vel_left  (req_vel_left),
      .vel_right (req_vel_right),
      .q_center  (req_q_center),
      .scaled    (scaled)
   );

   assign flux_diff = sat_word(ext_word(flux_right) - ext_word(flux_left));
   assign res_in    = sat_word(ext_word(scaled) - ext_word(flux_diff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= '0;
         vld_ff   <= '0;
      end else begin
         ratio_ff <= ratio_in;
         vld_ff   <= vld_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_new_q = res_ff;

   // every result strobe traces back to a word taken earlier on start
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, STAGES))
      else $error("result strobe without a source word");

   // a taken word with no reset in between produces a strobe
   a_word_not_lost: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##STAGES (rsp_valid || $past(reset, STAGES - 1) ||
         $past(reset, STAGES - 2) || $past(reset, STAGES - 3) ||
         $past(reset, STAGES - 4) || $past(reset, STAGES - 5) || $past(reset, 1) ||
         reset))
      else $error("accepted word produced no result");

   // a register write lands on the following edge
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (ratio_ff == $past(csr_data)))
      else $error("courant ratio write lost");

endmodule

// ===== tb/advection_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// advection_checker
// Watches the cell, config and result channels of the advection cell,
// predicts every new_q from its own fixed-point model and compares it with
// the result that comes out, in order.
// ---------------------------------------------------------------------------
module advection_checker
   import flux_adv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      busy,
   input  word_type  req_q_minus2,
   input  word_type  req_q_minus1,
   input  word_type  req_q_center,
   input  word_type  req_q_plus1,
   input  word_type  req_q_plus2,
   input  word_type  req_vel_left,
   input  word_type  req_vel_right,
   input  logic      rsp_valid,
   input  word_type  rsp_new_q,
   input  logic      csr_valid,
   input  logic      csr_ready,
   input  ratio_type csr_data,
   output int        mismatches,
   output int        pending,
   output int        checked
);

   localparam longint TOP_WORD    = 64'sd2147483647;
   localparam longint BOTTOM_WORD = -64'sd2147483648;
   localparam int     MAX_PRINTS  = 30;

   word_type  expected_new_q[$];
   ratio_type ratio_now;
   int        fail_tally;
   int        checked_tally;

   function automatic longint clamp_word(input longint x);
      if (x > TOP_WORD) begin
         return TOP_WORD;
      end else if (x < BOTTOM_WORD) begin
         return BOTTOM_WORD;
      end
      return x;
   endfunction

   // round half toward plus infinity; >>> on longint floors
   function automatic longint round_shr(input longint x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint q_product(input longint a, input longint b);
      return clamp_word(round_shr(a * b, FRAC_BITS));
   endfunction

   // q_a, q_b left of the face, q_c, q_d right of it
   function automatic longint upwind_flux(input longint vel, input longint q_a,
                                          input longint q_b, input longint q_c,
                                          input longint q_d, input longint ratio);
      longint one;
      longint mag;
      longint courant;
      longint one_minus_r;
      longint quarter;
      longint base;
      longint slope;
      one         = longint'(1) <<< FRAC_BITS;
      mag         = (vel < 0) ? -vel : vel;
      courant     = clamp_word(round_shr(mag * ratio, FRAC_BITS));
      one_minus_r = clamp_word(one - courant);
      quarter     = clamp_word(round_shr(one_minus_r, 2));
      if (vel >= 0) begin
         base  = q_b;
         slope = clamp_word(q_c - q_a);
      end else begin
         base  = clamp_word(-q_c);
         slope = clamp_word(q_d - q_b);
      end
      return q_product(courant, clamp_word(base + q_product(quarter, slope)));
   endfunction

   function automatic word_type advect_cell(input word_type qm2, input word_type qm1,
                                            input word_type q0, input word_type qp1,
                                            input word_type qp2, input word_type vl,
                                            input word_type vr, input ratio_type ratio);
      longint ratio_l;
      longint flux_left;
      longint flux_right;
      longint dvel;
      longint growth;
      longint result;
      ratio_l    = longint'(ratio);
      flux_left  = upwind_flux(longint'(vl), longint'(qm2), longint'(qm1),
                               longint'(q0), longint'(qp1), ratio_l);
      flux_right = upwind_flux(longint'(vr), longint'(qm1), longint'(q0),
                               longint'(qp1), longint'(qp2), ratio_l);
      dvel       = clamp_word(longint'(vr) - longint'(vl));
      growth     = clamp_word((longint'(1) <<< FRAC_BITS) + q_product(dvel, ratio_l));
      result     = clamp_word(q_product(longint'(q0), growth)
                              - clamp_word(flux_right - flux_left));
      return word_type'(result);
   endfunction

   task automatic report_mismatch(input string msg);
      fail_tally++;
      if (fail_tally <= MAX_PRINTS) begin
         $display("%0t ns  mismatch: %s", $time, msg);
      end
   endtask

   initial begin
      fail_tally    = 0;
      checked_tally = 0;
      ratio_now     = '0;
      mismatches    = 0;
      pending       = 0;
      checked       = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_new_q.delete();
         ratio_now = '0;
      end else begin
         if (rsp_valid) begin
            if (expected_new_q.size() == 0) begin
               report_mismatch($sformatf("new_q %h with no word outstanding", rsp_new_q));
            end else begin
               if (rsp_new_q !== expected_new_q[0]) begin
                  report_mismatch($sformatf("new_q got %h want %h",
                                            rsp_new_q, expected_new_q[0]));
               end
               void'(expected_new_q.pop_front());
               checked_tally++;
            end
         end
         if (start && !busy) begin
            expected_new_q.push_back(advect_cell(req_q_minus2, req_q_minus1, req_q_center,
                                                 req_q_plus1, req_q_plus2, req_vel_left,
                                                 req_vel_right, ratio_now));
         end
         if (csr_valid && csr_ready) begin
            ratio_now = csr_data;
         end
      end
      mismatches <= fail_tally;
      pending    <= expected_new_q.size();
      checked    <= checked_tally;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives the flux-form advection cell with directed stencil windows and
// bursts of random ones under a range of courant ratios; the checker
// predicts and compares every new_q.
// ---------------------------------------------------------------------------
module testbench;
   import flux_adv_pkg::*;

   localparam int  HOLD_OFF    = STAGES + 4;
   localparam int  CYCLE_LIMIT = 200000;
   localparam int  PHASE_ITEMS = 70;
   localparam word_type W_MAX  = 32'sh7fffffff;
   localparam word_type W_MIN  = 32'sh80000000;
   localparam word_type W_ONE  = 32'sh00010000;

   typedef struct packed {
      word_type q_minus2;
      word_type q_minus1;
      word_type q_center;
      word_type q_plus1;
      word_type q_plus2;
      word_type vel_left;
      word_type vel_right;
   } cell_window_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   word_type  req_q_minus2;
   word_type  req_q_minus1;
   word_type  req_q_center;
   word_type  req_q_plus1;
   word_type  req_q_plus2;
   word_type  req_vel_left;
   word_type  req_vel_right;
   logic      rsp_valid;
   word_type  rsp_new_q;
   logic      csr_valid;
   logic      csr_ready;
   ratio_type csr_data;

   int mismatches;
   int pending;
   int checked;
   int cells_sent;
   int ratio_writes;
   int cycle_count;

   flux_form_advection_cell_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_q_minus2  (req_q_minus2),
      .req_q_minus1  (req_q_minus1),
      .req_q_center  (req_q_center),
      .req_q_plus1   (req_q_plus1),
      .req_q_plus2   (req_q_plus2),
      .req_vel_left  (req_vel_left),
      .req_vel_right (req_vel_right),
      .rsp_valid     (rsp_valid),
      .rsp_new_q     (rsp_new_q),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   advection_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_q_minus2  (req_q_minus2),
      .req_q_minus1  (req_q_minus1),
      .req_q_center  (req_q_center),
      .req_q_plus1   (req_q_plus1),
      .req_q_plus2   (req_q_plus2),
      .req_vel_left  (req_vel_left),
      .req_vel_right (req_vel_right),
      .rsp_valid     (rsp_valid),
      .rsp_new_q     (rsp_new_q),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .pending       (pending),
      .checked       (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic cell_window_type make_window(input word_type qm2, input word_type qm1,
                                                   input word_type q0, input word_type qp1,
                                                   input word_type qp2, input word_type vl,
                                                   input word_type vr);
      cell_window_type w;
      w.q_minus2  = qm2;
      w.q_minus1  = qm1;
      w.q_center  = q0;
      w.q_plus1   = qp1;
      w.q_plus2   = qp2;
      w.vel_left  = vl;
      w.vel_right = vr;
      return w;
   endfunction

   // scalars: extremes, small values near the grid, or any pattern
   function automatic word_type random_scalar();
      case ($urandom_range(0, 9))
         0: return W_MAX;
         1: return W_MIN;
         2: return '0;
         3: return word_type'($urandom_range(0, 32'h1fffff)) - 32'sh100000;
         4, 5: return word_type'($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
         default: return word_type'($urandom);
      endcase
   endfunction

   // velocities: mostly within four units of zero, plus extremes and any pattern
   function automatic word_type random_velocity();
      case ($urandom_range(0, 11))
         0: return W_MAX;
         1: return W_MIN;
         2: return '0;
         3: return word_type'($urandom);
         4: return word_type'($urandom_range(0, 32'h1fffffff)) - 32'sh10000000;
         default: return word_type'($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      endcase
   endfunction

   function automatic cell_window_type random_window();
      return make_window(random_scalar(), random_scalar(), random_scalar(),
                         random_scalar(), random_scalar(),
                         random_velocity(), random_velocity());
   endfunction

   task automatic send_cell(input cell_window_type w);
      @(negedge clock);
      start         <= 1'b1;
      req_q_minus2  <= w.q_minus2;
      req_q_minus1  <= w.q_minus1;
      req_q_center  <= w.q_center;
      req_q_plus1   <= w.q_plus1;
      req_q_plus2   <= w.q_plus2;
      req_vel_left  <= w.vel_left;
      req_vel_right <= w.vel_right;
      @(posedge clock);
      while (busy) @(posedge clock);
      cells_sent++;
   endtask

   // junk on the fields while start is low must be ignored
   task automatic idle_cycles(input int n);
      cell_window_type junk;
      repeat (n) begin
         junk = random_window();
         @(negedge clock);
         start         <= 1'b0;
         req_q_minus2  <= junk.q_minus2;
         req_q_minus1  <= junk.q_minus1;
         req_q_center  <= junk.q_center;
         req_q_plus1   <= junk.q_plus1;
         req_q_plus2   <= junk.q_plus2;
         req_vel_left  <= junk.vel_left;
         req_vel_right <= junk.vel_right;
      end
   endtask

   task automatic drain_pipeline();
      idle_cycles(1);
      while (pending != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_ratio(input ratio_type value);
      drain_pipeline();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      ratio_writes++;
   endtask

   task automatic random_phase(input int n_items);
      int left;
      int burst;
      left = n_items;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) begin
            burst = left;
         end
         repeat (burst) send_cell(random_window());
         left -= burst;
         if ($urandom_range(0, 15) == 0) begin
            drain_pipeline();
         end else if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      cell_window_type directed[$];
      ratio_type       phase_ratio[$];

      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_q_minus2  = '0;
      req_q_minus1  = '0;
      req_q_center  = '0;
      req_q_plus1   = '0;
      req_q_plus2   = '0;
      req_vel_left  = '0;
      req_vel_right = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      cells_sent    = 0;
      ratio_writes  = 0;
      cycle_count   = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ratio still at its reset value of zero
      send_cell(make_window(W_ONE, 2 * W_ONE, 3 * W_ONE, 4 * W_ONE, 5 * W_ONE, W_ONE, -W_ONE));
      send_cell(make_window(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX));

      write_ratio(20'h08000);
      directed.push_back(make_window('0, '0, '0, '0, '0, '0, '0));
      directed.push_back(make_window(W_ONE, 2 * W_ONE, 3 * W_ONE, 4 * W_ONE, 5 * W_ONE,
                                     W_ONE, W_ONE));
      directed.push_back(make_window(W_ONE, 2 * W_ONE, 3 * W_ONE, 4 * W_ONE, 5 * W_ONE,
                                     -W_ONE, -W_ONE));
      directed.push_back(make_window(5 * W_ONE, -W_ONE, 7 * W_ONE, 2 * W_ONE, -3 * W_ONE,
                                     W_ONE, -W_ONE));
      directed.push_back(make_window(5 * W_ONE, -W_ONE, 7 * W_ONE, 2 * W_ONE, -3 * W_ONE,
                                     -W_ONE, W_ONE));
      // zero velocity on one face, upwind branch
      directed.push_back(make_window(3 * W_ONE, W_ONE, -2 * W_ONE, 4 * W_ONE, W_ONE,
                                     '0, -W_ONE));
      directed.push_back(make_window(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
      directed.push_back(make_window(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
      // negating the most negative scalar saturates
      directed.push_back(make_window('0, '0, W_MIN, '0, '0, -W_ONE, W_ONE));
      directed.push_back(make_window('0, '0, '0, W_MIN, '0, W_ONE, -W_ONE));
      // courant number above one gives a negative 1-r
      directed.push_back(make_window(W_ONE, 3 * W_ONE, -W_ONE, 2 * W_ONE, 6 * W_ONE,
                                     4 * W_ONE, 6 * W_ONE));
      directed.push_back(make_window(W_ONE, 3 * W_ONE, -W_ONE, 2 * W_ONE, 6 * W_ONE,
                                     -4 * W_ONE, -6 * W_ONE));
      // growth factor drives new_q past either rail
      directed.push_back(make_window('0, '0, W_MAX, '0, '0, W_MIN, W_MAX));
      directed.push_back(make_window('0, '0, W_MIN, '0, '0, W_MIN, W_MAX));
      directed.push_back(make_window(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
                                     32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                                     32'shaaaaaaaa));
      directed.push_back(make_window(-32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1,
                                     32'sd1, -32'sd1));
      foreach (directed[i]) send_cell(directed[i]);

      write_ratio(20'hfffff);
      send_cell(make_window(W_ONE, -W_ONE, W_ONE, -W_ONE, W_ONE, W_ONE, -W_ONE));
      send_cell(make_window(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN));
      write_ratio(20'h10000);
      send_cell(make_window(W_ONE, 2 * W_ONE, 4 * W_ONE, 8 * W_ONE, 16 * W_ONE,
                            W_ONE, -W_ONE));
      send_cell(make_window(W_ONE, 2 * W_ONE, 4 * W_ONE, 8 * W_ONE, 16 * W_ONE,
                            -W_ONE, W_ONE));

      phase_ratio = '{20'h10000, 20'h00000, 20'hfffff, 20'h00001, 20'h04000,
                      20'h00000, 20'h00000, 20'h00000, 20'h00000};
      for (int p = 5; p < phase_ratio.size(); p++) begin
         phase_ratio[p] = ratio_type'($urandom_range(0, 20'hfffff));
      end
      foreach (phase_ratio[p]) begin
         write_ratio(phase_ratio[p]);
         random_phase(PHASE_ITEMS);
      end

      drain_pipeline();
      $display("summary: %0d cells sent, %0d new_q checked over %0d courant ratio writes",
               cells_sent, checked, ratio_writes);
      $display("summary: zero, unit and full-scale ratios, upwind branches both ways, rails");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/flux_adv_pkg.sv
rtl/core/flux_adv_face.sv
rtl/core/flux_adv_growth.sv
rtl/core/flux_advection_cell_top.sv
tb/advection_checker.sv
tb/testbench.sv
